// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is low.
`define ITA_ASSERT(LBL, CLK, RSTN, PROP) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
    else $error("%m: check failed");

// Clocked check that also holds across reset.
`define ITA_ASSERT_ALWAYS(LBL, CLK, PROP) \
  LBL: assert property (@(posedge CLK) PROP) \
    else $error("%m: check failed");

`endif

// ===== rtl/ita_pkg.sv =====
`default_nettype none

package ita_pkg;

  // Field widths
  localparam int FUNC_W     = 3;
  localparam int IN_VALUE_W = 64;
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int DIGIT_W    = 4;

  // Default pointer width
  localparam int VALUE_WIDTH_DEF = 64;

  // 32-bit conversions
  localparam int DEC_BITS   = 32;
  localparam int DEC_DIGITS = 10;
  localparam int RADIX_DEC  = 10;

  // Conversion selectors
  localparam logic [FUNC_W-1:0] FN_SDEC = 3'd0;
  localparam logic [FUNC_W-1:0] FN_UDEC = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LHEX = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UHEX = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PTR  = 3'd4;

  // Characters
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Digit cell operations
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DABBLE = 2'd2,
    OP_SHIFT  = 2'd3
  } cell_op_t;

  // One digit (0..15) to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                       input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UP_A : CH_LOW_A;
    if (d < DIGIT_W'(RADIX_DEC)) begin
      digit_to_ascii = CH_ZERO + CHAR_W'(d);
    end else begin
      digit_to_ascii = base + CHAR_W'(d) - CHAR_W'(RADIX_DEC);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ita_cell.sv =====
`default_nettype none

// One digit position of the conversion chain.
module ita_cell import ita_pkg::*; (
  input  logic               clk,
  input  cell_op_t           op,
  input  logic [DIGIT_W-1:0] load_digit,
  input  logic               bit_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic [DIGIT_W-1:0] digit,
  output logic               carry_out
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // add-3 correction ahead of the shift
  always_comb begin
    adj = (digit_r >= DIGIT_W'(5)) ? (digit_r + DIGIT_W'(3)) : digit_r;
  end

  assign carry_out = adj[DIGIT_W-1];
  assign digit     = digit_r;

  // next digit
  always_comb begin
    case (op)
      OP_HOLD:   digit_nxt = digit_r;
      OP_LOAD:   digit_nxt = load_digit;
      OP_DABBLE: digit_nxt = {adj[DIGIT_W-2:0], bit_in};
      OP_SHIFT:  digit_nxt = digit_in;
      default:   digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
// Sequence: on accept (start while idle) the digit cells load; decimal items then run the
// 32-step shift-and-add-3 pass. Leading zero digits are shifted out, keeping at least one,
// a minus sign leads a negative signed decimal, and the digits follow most significant first;
// the digit chain shifts one position per cycle.
// Output: one character per cycle on out_valid, never stalled by the receiver.
// Reset (synchronous, rst_n low) clears control and strobe; the digit cells are not reset.
`default_nettype none

module integer_to_ascii_formatter import ita_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [IN_VALUE_W-1:0] in_value,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_ascii_char,
  output logic                  out_last,
  output logic [COUNT_W-1:0]    out_char_count
);

  localparam int PTR_DIGITS = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int NCELL      = (PTR_DIGITS > DEC_DIGITS) ? PTR_DIGITS : DEC_DIGITS;
  localparam int REM_W      = $clog2(NCELL + 1);
  localparam int BITCNT_W   = $clog2(DEC_BITS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DABBLE = 5'b00010,
    ST_SKIP   = 5'b00100,
    ST_SIGN   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [DEC_BITS-1:0]   bin_r, bin_nxt;
  logic [BITCNT_W-1:0]   bitcnt_r, bitcnt_nxt;
  logic [REM_W-1:0]      remain_r, remain_nxt;
  logic                  neg_r, neg_nxt;
  logic                  upper_r, upper_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic                  valid_r, valid_nxt;
  logic [CHAR_W-1:0]     char_r, char_nxt;
  logic                  last_r, last_nxt;

  cell_op_t              cell_op;
  logic [NCELL*DIGIT_W-1:0] load_vec;
  logic [DEC_BITS-1:0]   low32;
  logic [DEC_BITS-1:0]   mag;
  logic                  is_dec;
  logic [DIGIT_W-1:0]    digit_w [NCELL];
  logic                  carry_w [NCELL];
  logic [DIGIT_W-1:0]    top_digit;

  assign busy           = !state_r[0];
  assign out_valid      = valid_r;
  assign out_ascii_char = char_r;
  assign out_last       = last_r;
  assign out_char_count = cnt_r;
  assign top_digit      = digit_w[NCELL-1];

  // operand preparation
  assign low32  = in_value[DEC_BITS-1:0];
  assign is_dec = (in_func == FN_SDEC) || (in_func == FN_UDEC);
  assign mag    = ((in_func == FN_SDEC) && low32[DEC_BITS-1]) ?
                  (~low32 + DEC_BITS'(1)) : low32;

  // hex nibbles for the cell load; decimal loads zeros
  always_comb begin
    load_vec = '0;
    if (in_func == FN_PTR) begin
      load_vec[VALUE_WIDTH-1:0] = in_value[VALUE_WIDTH-1:0];
    end else if ((in_func == FN_LHEX) || (in_func == FN_UHEX)) begin
      load_vec[DEC_BITS-1:0] = low32;
    end
  end

  // digit chain, cell 0 least significant
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic               bit_in;
    logic [DIGIT_W-1:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = bin_r[DEC_BITS-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry_w[i-1];
      assign digit_in = digit_w[i-1];
    end
    ita_cell u_cell (
      .clk        (clk),
      .op         (cell_op),
      .load_digit (load_vec[i*DIGIT_W +: DIGIT_W]),
      .bit_in     (bit_in),
      .digit_in   (digit_in),
      .digit      (digit_w[i]),
      .carry_out  (carry_w[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    bin_nxt    = bin_r;
    bitcnt_nxt = bitcnt_r;
    remain_nxt = remain_r;
    neg_nxt    = neg_r;
    upper_nxt  = upper_r;
    cnt_nxt    = cnt_r;
    valid_nxt  = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    cell_op    = OP_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (start && (in_func <= FN_PTR)) begin
          cell_op    = OP_LOAD;
          bin_nxt    = mag;
          bitcnt_nxt = '0;
          remain_nxt = REM_W'(NCELL);
          neg_nxt    = (in_func == FN_SDEC) && low32[DEC_BITS-1];
          upper_nxt  = (in_func == FN_UHEX);
          cnt_nxt    = '0;
          state_nxt  = is_dec ? ST_DABBLE : ST_SKIP;
        end
      end
      ST_DABBLE: begin
        cell_op    = OP_DABBLE;
        bin_nxt    = {bin_r[DEC_BITS-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r + BITCNT_W'(1);
        if (bitcnt_r == BITCNT_W'(DEC_BITS - 1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if ((top_digit == '0) && (remain_r != REM_W'(1))) begin
          cell_op    = OP_SHIFT;
          remain_nxt = remain_r - REM_W'(1);
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_MINUS;
        last_nxt  = 1'b0;
        cnt_nxt   = cnt_r + COUNT_W'(1);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        valid_nxt  = 1'b1;
        char_nxt   = digit_to_ascii(top_digit, upper_r);
        last_nxt   = (remain_r == REM_W'(1));
        cnt_nxt    = cnt_r + COUNT_W'(1);
        cell_op    = OP_SHIFT;
        remain_nxt = remain_r - REM_W'(1);
        if (remain_r == REM_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bin_r    <= bin_nxt;
    bitcnt_r <= bitcnt_nxt;
    remain_r <= remain_nxt;
    neg_r    <= neg_nxt;
    upper_r  <= upper_nxt;
    cnt_r    <= cnt_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/ita_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the character stream.
module ita_checker import ita_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [CHAR_W-1:0]  out_ascii_char,
  input wire logic               out_last,
  input wire logic [COUNT_W-1:0] out_char_count
);

  // reset leaves the block idle and silent
  `ITA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> (!out_valid && !busy))

  // a run continues without gaps and counts up by one
  `ITA_ASSERT(a_run_steps, clk, rst_n, (out_valid && !out_last) |=> (out_valid && (out_char_count == ($past(out_char_count) + COUNT_W'(1)))))

  // every run opens at count one
  `ITA_ASSERT(a_run_opens, clk, rst_n, (out_valid && !$past(out_valid)) |-> (out_char_count == COUNT_W'(1)))

  // a minus sign only leads a run and never ends it
  `ITA_ASSERT(a_sign_first, clk, rst_n, (out_valid && (out_ascii_char == CH_MINUS)) |-> ((out_char_count == COUNT_W'(1)) && !out_last))

  // the last character is followed by a gap
  `ITA_ASSERT(a_last_gap, clk, rst_n, (out_valid && out_last) |=> !out_valid)

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_ascii_char (out_ascii_char),
  .out_last       (out_last),
  .out_char_count (out_char_count)
);

`default_nettype wire
